>>> hw/rtl/odometry_grid_localizer_assert.svh
// Assertion macros for the odometry grid localizer RTL.
// Included by the controller, which checks its own control logic.
`ifndef ODOMETRY_GRID_LOCALIZER_ASSERT_SVH
`define ODOMETRY_GRID_LOCALIZER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define OGL_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define OGL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/ogl_pkg.sv
// Package for the odometry grid localizer: constants, types, sine table.
// Used by the datapath, controller and top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ogl_pkg;
   localparam int SensorCount = 12;
   localparam int PosFracBits = 8;
   localparam int SensIdxW = 4;
   localparam int PosW = 18 + PosFracBits;

   localparam logic [1:0] OpOdometry = 2'd0;
   localparam logic [1:0] OpLoad = 2'd1;
   localparam logic [1:0] OpObserve = 2'd2;
   localparam logic [1:0] OpUnused = 2'd3;

   localparam logic [2:0] RegGain = 3'd0;
   localparam logic [2:0] RegCell = 3'd1;
   localparam logic [2:0] RegLimit = 3'd2;
   localparam logic [2:0] RegWall = 3'd3;
   localparam logic [2:0] RegMargin = 3'd4;

   // Datapath commands issued by the controller.
   typedef enum logic [3:0] {
      CmdNone, CmdLatch, CmdLoad, CmdOdoMulA, CmdOdoMulB, CmdOdoAdd,
      CmdSearch, CmdWidth, CmdDivStart, CmdDivStep, CmdSnap, CmdNextAxis
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    axis;
   } ctl_type;

   typedef struct packed {
      logic [1:0] op;
      logic       search_done;
      logic       div_done;
      logic       trust_sel;
   } sts_type;

   // Quarter-wave sine, Q14, whole degrees 0..90.
   function automatic logic [14:0] sin_quarter(input logic [6:0] d);
      logic [14:0] t [0:90];
      t = '{15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713,
         15'd1997, 15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686,
         15'd3964, 15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604,
         15'd5872, 15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438,
         15'd7692, 15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162,
         15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531,
         15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
         15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911,
         15'd13085, 15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894,
         15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
         15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
         15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
         15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225,
         15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
         15'd16382, 15'd16384};
      if (d > 7'd90) begin
         return 15'd0;
      end
      return t[d];
   endfunction

   // Signed sine of a degree value in 0..359, Q14.
   function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
      logic [14:0] m;
      logic neg;
      neg = 1'b0;
      if (d <= 9'd90) begin
         m = sin_quarter(d[6:0]);
      end else if (d <= 9'd180) begin
         m = sin_quarter(7'(9'd180 - d));
      end else if (d <= 9'd270) begin
         m = sin_quarter(7'(d - 9'd180));
         neg = 1'b1;
      end else begin
         m = sin_quarter(7'(9'd360 - d));
         neg = 1'b1;
      end
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   // Mounting angle of a sensor slot, computed as 360 - slot*360/SensorCount.
   function automatic logic [8:0] mount_angle(input logic [SensIdxW-1:0] i);
      logic [8:0] a;
      a = 9'd0;
      for (int j = 0; j < SensorCount; j++) begin
         if (32'(i) == j) begin
            a = 9'(360 - (j * 360) / SensorCount);
         end
      end
      return a;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ogl_if.sv
// Valid/ready channel interfaces for request, response and register writes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ogl_req_if;
   logic valid;
   logic ready;
   logic [1:0] op;
   logic signed [15:0] right_speed;
   logic signed [15:0] left_speed;
   logic [8:0] heading;
   logic [3:0] sensor_index;
   logic signed [12:0] sensor_dx;
   logic signed [12:0] sensor_dy;
   modport source (output valid, op, right_speed, left_speed, heading,
      sensor_index, sensor_dx, sensor_dy, input ready);
   modport sink (input valid, op, right_speed, left_speed, heading,
      sensor_index, sensor_dx, sensor_dy, output ready);
endinterface

interface ogl_rsp_if;
   logic valid;
   logic ready;
   logic signed [17:0] pos_x_mm;
   logic signed [17:0] pos_y_mm;
   logic signed [9:0] cell_x;
   logic signed [9:0] cell_y;
   logic trust_x;
   logic trust_y;
   modport source (output valid, pos_x_mm, pos_y_mm, cell_x, cell_y, trust_x,
      trust_y, input ready);
   modport sink (input valid, pos_x_mm, pos_y_mm, cell_x, cell_y, trust_x,
      trust_y, output ready);
endinterface

interface ogl_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ogl_datapath.sv
// Datapath: registers, sensor store, multiplier, serial divider, snapping.
// Depends on ogl_pkg and ogl_if.
`timescale 1ns / 1ps
`default_nettype none
module ogl_datapath (
   input  wire logic           clock,
   input  wire logic           reset,
   ogl_req_if.sink             req,
   ogl_csr_if.sink             csr,
   input  wire ogl_pkg::ctl_type ctl,
   output ogl_pkg::sts_type    sts,
   output logic signed [17:0]  pos_x_mm,
   output logic signed [17:0]  pos_y_mm,
   output logic signed [9:0]   cell_x,
   output logic signed [9:0]   cell_y,
   output logic                trust_x,
   output logic                trust_y
);
   localparam int PW = ogl_pkg::PosW;
   localparam int NW = PW + 1;
   localparam int SC = ogl_pkg::SensorCount;
   localparam int IW = ogl_pkg::SensIdxW;
   localparam logic signed [PW-1:0] PMax = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] PMin = {1'b1, {(PW-1){1'b0}}};
   localparam int Sh = 31 - ogl_pkg::PosFracBits;

   // Configuration registers.
   logic [23:0] gain_ff;
   logic [11:0] cell_ff, limit_ff, wall_ff, margin_ff;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 24'd65536;
         cell_ff <= 12'd300;
         limit_ff <= 12'd310;
         wall_ff <= 12'd130;
         margin_ff <= 12'd40;
      end else if (csr.valid) begin
         unique case (csr.index)
            ogl_pkg::RegGain: gain_ff <= csr.data;
            ogl_pkg::RegCell: cell_ff <= csr.data[11:0];
            ogl_pkg::RegLimit: limit_ff <= csr.data[11:0];
            ogl_pkg::RegWall: wall_ff <= csr.data[11:0];
            ogl_pkg::RegMargin: margin_ff <= csr.data[11:0];
            default: ;
         endcase
      end
   end
   wire [11:0] cell_eff = (cell_ff == 12'd0) ? 12'd1 : cell_ff;

   // Latched request.
   logic [1:0] op_ff;
   logic signed [16:0] sum_ff;
   logic [8:0] head_ff;
   logic [3:0] idx_ff;
   logic signed [12:0] dx_ff, dy_ff;
   wire [9:0] h_mod = (req.heading >= 9'd360) ? 10'(req.heading) - 10'd360
      : 10'(req.heading);
   always_ff @(posedge clock) begin
      if (ctl.cmd == ogl_pkg::CmdLatch) begin
         op_ff <= req.op;
         sum_ff <= 17'(req.right_speed) + 17'(req.left_speed);
         head_ff <= h_mod[8:0];
         idx_ff <= req.sensor_index;
         dx_ff <= req.sensor_dx;
         dy_ff <= req.sensor_dy;
      end
   end

   // Sensor store; reset clears it as the reset value is zero.
   logic signed [12:0] sx_ff [SC];
   logic signed [12:0] sy_ff [SC];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SC; i++) begin
            sx_ff[i] <= '0;
            sy_ff[i] <= '0;
         end
      end else if (ctl.cmd == ogl_pkg::CmdLoad && 32'(idx_ff) < SC) begin
         sx_ff[idx_ff[IW-1:0]] <= dx_ff;
         sy_ff[idx_ff[IW-1:0]] <= dy_ff;
      end
   end

   // Position registers and trust flags.
   logic signed [PW-1:0] pos_ff [2];
   logic trust_ff [2];

   // Odometry: sum*sin then times gain, two registered multiplies.
   logic signed [32:0] p1_ff;
   logic signed [58:0] p2_ff;
   wire [8:0] ang = ctl.axis ? ((head_ff >= 9'd270) ? head_ff - 9'd270
      : head_ff + 9'd90) : head_ff;
   wire signed [15:0] sv = ogl_pkg::sin_deg(ang);
   wire [57:0] mag2 = p2_ff[58] ? 58'(-p2_ff) : p2_ff[57:0];
   wire [57:0] q2 = (mag2 + (58'd1 << (Sh - 1))) >> Sh;
   wire signed [59:0] q2s = p2_ff[58] ? -$signed({2'b0, q2}) : $signed({2'b0, q2});
   wire signed [59:0] nsum = 60'(pos_ff[ctl.axis]) + q2s;
   wire signed [PW-1:0] nsat = (nsum > 60'(PMax)) ? PMax :
      (nsum < 60'(PMin)) ? PMin : PW'(nsum);

   // Nearest-sensor search, one slot per cycle.
   logic [IW-1:0] sidx_ff, best_ff;
   logic [8:0] beste_ff;
   wire [8:0] ma = ogl_pkg::mount_angle(sidx_ff);
   wire [8:0] dd = (ma >= head_ff) ? ma - head_ff : head_ff - ma;
   wire [8:0] ee = (dd < 9'd360 - dd) ? dd : 9'd360 - dd;
   wire srch_last = 32'(sidx_ff) == SC - 1;
   function automatic logic [IW-1:0] wrap(input logic [IW-1:0] b, input int o);
      logic [IW:0] s;
      s = (IW+1)'(b) + (IW+1)'(o);
      return (32'(s) >= SC) ? IW'(32'(s) - SC) : s[IW-1:0];
   endfunction
   wire [IW-1:0] ix1 = wrap(best_ff, SC / 4);
   wire [IW-1:0] ix3 = wrap(best_ff, (3 * SC) / 4);
   wire [IW-1:0] iy2 = wrap(best_ff, SC / 2);
   wire signed [12:0] ra = ctl.axis ? sy_ff[best_ff] : sx_ff[ix1];
   wire signed [12:0] rb = ctl.axis ? sy_ff[iy2] : sx_ff[ix3];
   wire [12:0] aa = ra[12] ? 13'(-ra) : ra;
   wire [12:0] ab = rb[12] ? 13'(-rb) : rb;
   wire [14:0] wid = 15'(aa) + 15'(ab) + 15'(margin_ff);

   // Serial divider: |2p| + den over 2den, restoring, one bit per cycle.
   localparam int DW = NW + 2;
   localparam int DDW = 12 + ogl_pkg::PosFracBits + 1;
   logic [DW-1:0] dq_ff;
   logic [DDW:0] drem_ff;
   logic [5:0] dcnt_ff;
   logic dneg_ff;
   wire [DDW-1:0] den2 = DDW'({cell_eff, {ogl_pkg::PosFracBits{1'b0}}, 1'b0});
   wire signed [PW-1:0] dsrc = pos_ff[ctl.axis];
   wire [PW-1:0] dmag = dsrc[PW-1] ? PW'(-dsrc) : dsrc;
   wire [DDW:0] trial = {drem_ff[DDW-1:0], dq_ff[DW-1]};
   wire tge = trial >= (DDW+1)'(den2);
   wire signed [DW:0] kq = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   logic signed [9:0] cell_ff2 [2];

   // Snap: k*cell + |rear or left reading| - wall, scaled and saturated.
   wire signed [DW+14:0] mm = kq * $signed({1'b0, cell_eff}) +
      $signed((DW+15)'(ab)) - $signed((DW+15)'(wall_ff));
   wire signed [DW+14:0] mmx = mm <<< ogl_pkg::PosFracBits;
   wire signed [PW-1:0] ssat = (mmx > (DW+15)'(PMax)) ? PMax :
      (mmx < (DW+15)'(PMin)) ? PMin : PW'(mmx);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         trust_ff[0] <= 1'b0;
         trust_ff[1] <= 1'b0;
         cell_ff2[0] <= '0;
         cell_ff2[1] <= '0;
         dcnt_ff <= '0;
      end else begin
         unique case (ctl.cmd)
            ogl_pkg::CmdOdoMulA: p1_ff <= sum_ff * sv;
            ogl_pkg::CmdOdoMulB: p2_ff <= p1_ff * $signed({1'b0, gain_ff});
            ogl_pkg::CmdOdoAdd: pos_ff[ctl.axis] <= nsat;
            ogl_pkg::CmdSearch: begin
               if (sidx_ff == '0 || ee < beste_ff) begin
                  beste_ff <= ee;
                  best_ff <= sidx_ff;
               end
               sidx_ff <= srch_last ? '0 : sidx_ff + 1'b1;
            end
            ogl_pkg::CmdWidth: begin
               trust_ff[ctl.axis] <= wid < 15'(limit_ff);
            end
            ogl_pkg::CmdDivStart: begin
               dq_ff <= DW'({dmag, 1'b0}) + DW'(den2 >> 1);
               drem_ff <= '0;
               dneg_ff <= dsrc[PW-1];
               dcnt_ff <= 6'(DW);
            end
            ogl_pkg::CmdDivStep: begin
               drem_ff <= tge ? trial - (DDW+1)'(den2) : trial;
               dq_ff <= {dq_ff[DW-2:0], tge};
               dcnt_ff <= dcnt_ff - 1'b1;
            end
            ogl_pkg::CmdSnap: pos_ff[ctl.axis] <= ssat;
            ogl_pkg::CmdNextAxis: begin
               cell_ff2[ctl.axis] <= (kq > 511) ? 10'sd511 :
                  (kq < -512) ? -10'sd512 : 10'(kq);
            end
            ogl_pkg::CmdLatch: begin
               sidx_ff <= '0;
               beste_ff <= 9'd360;
            end
            default: ;
         endcase
      end
   end

   assign sts.op = op_ff;
   assign sts.search_done = srch_last;
   assign sts.div_done = dcnt_ff == 6'd1;
   assign sts.trust_sel = trust_ff[ctl.axis];

   // Output fields.
   assign pos_x_mm = pos_ff[0][PW-1:ogl_pkg::PosFracBits];
   assign pos_y_mm = pos_ff[1][PW-1:ogl_pkg::PosFracBits];
   assign cell_x = cell_ff2[0];
   assign cell_y = cell_ff2[1];
   assign trust_x = trust_ff[0];
   assign trust_y = trust_ff[1];
endmodule
`default_nettype wire

>>> hw/rtl/ogl_controller.sv
// Controller state machine sequencing one item through the datapath.
// Depends on ogl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "odometry_grid_localizer_assert.svh"
module ogl_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire ogl_pkg::sts_type sts,
   output ogl_pkg::ctl_type      ctl
);
   typedef enum logic [3:0] {
      SIdle, SDecode, SMulA, SMulB, SAdd, SSearch, SWidth, SDivStart, SDiv,
      SSnap, SRedo, SDone
   } state_type;
   state_type state_ff, state_in;
   logic axis_ff, axis_in;
   logic snapped_ff, snapped_in;

   // Next state, axis, snapping flag and datapath command.
   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      snapped_in = snapped_ff;
      ctl.axis = axis_ff;
      ctl.cmd = ogl_pkg::CmdNone;
      unique case (state_ff)
         SIdle: if (req_valid) begin
            ctl.cmd = ogl_pkg::CmdLatch;
            state_in = SDecode;
            axis_in = 1'b0;
         end
         SDecode: begin
            unique case (sts.op)
               ogl_pkg::OpOdometry: state_in = SMulA;
               ogl_pkg::OpLoad: begin
                  ctl.cmd = ogl_pkg::CmdLoad;
                  state_in = SDivStart;
               end
               ogl_pkg::OpObserve: state_in = SSearch;
               default: state_in = SDivStart;
            endcase
            snapped_in = 1'b0;
         end
         SMulA: begin
            ctl.cmd = ogl_pkg::CmdOdoMulA;
            state_in = SMulB;
         end
         SMulB: begin
            ctl.cmd = ogl_pkg::CmdOdoMulB;
            state_in = SAdd;
         end
         SAdd: begin
            ctl.cmd = ogl_pkg::CmdOdoAdd;
            axis_in = ~axis_ff;
            state_in = axis_ff ? SDivStart : SMulA;
         end
         SSearch: begin
            ctl.cmd = ogl_pkg::CmdSearch;
            if (sts.search_done) begin
               state_in = SWidth;
            end
         end
         SWidth: begin
            ctl.cmd = ogl_pkg::CmdWidth;
            axis_in = ~axis_ff;
            snapped_in = 1'b1;
            state_in = axis_ff ? SDivStart : SWidth;
         end
         SDivStart: begin
            ctl.cmd = ogl_pkg::CmdDivStart;
            state_in = SDiv;
         end
         SDiv: begin
            ctl.cmd = ogl_pkg::CmdDivStep;
            if (sts.div_done) begin
               state_in = SSnap;
            end
         end
         SSnap: begin
            // With snapping armed, a trusted axis is snapped and then its cell redone;
            // otherwise the cell index is stored and the next axis begins, or the item ends after the second axis.
            if (snapped_ff && sts.trust_sel) begin
               ctl.cmd = ogl_pkg::CmdSnap;
               state_in = SRedo;
            end else begin
               ctl.cmd = ogl_pkg::CmdNextAxis;
               axis_in = ~axis_ff;
               state_in = axis_ff ? SDone : SDivStart;
            end
         end
         SRedo: begin
            ctl.cmd = ogl_pkg::CmdDivStart;
            snapped_in = 1'b0;
            state_in = SDiv;
         end
         SDone: if (rsp_ready) begin
            state_in = SIdle;
         end
         default: state_in = SIdle;
      endcase
      // For an observe, re-arm snapping for the second axis once the first axis has finished.
      if (state_ff == SSnap && !axis_ff && !(snapped_ff && sts.trust_sel)
         && sts.op == ogl_pkg::OpObserve) begin
         snapped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         axis_ff <= 1'b0;
         snapped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         snapped_ff <= snapped_in;
      end
   end

   assign req_ready = state_ff == SIdle;
   assign rsp_valid = state_ff == SDone;

   `OGL_ASSERT_IMPL(a_excl, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `OGL_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `OGL_ASSERT_NEXT(a_take, clock, reset, req_valid && req_ready, !req_ready)
endmodule
`default_nettype wire

>>> hw/rtl/odometry_grid_localizer.sv
// Top level of the odometry grid localizer: controller plus datapath.
// Depends on ogl_pkg, ogl_if, ogl_controller and ogl_datapath.
//  channel | dir | contents
//  req     | in  | op, speeds, heading, sensor slot and reading
//  rsp     | out | position mm, cell indices, trust flags
//  csr     | in  | register index and write data
// One item at a time. Each axis runs the 29-step bit-serial cell
// divider, a snapped axis once more; odometry adds the multiplies
// and an observe the sensor search and the two width checks. Reset
// is synchronous and restores the controller, the configuration,
// position, trust and cell registers and the sensor store. The
// result holds in place until rsp is taken; req waits meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module odometry_grid_localizer (
   input wire logic clock,
   input wire logic reset,
   ogl_req_if.sink  req,
   ogl_rsp_if.source rsp,
   ogl_csr_if.sink  csr
);
   ogl_pkg::ctl_type ctl;
   ogl_pkg::sts_type sts;

   ogl_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .sts(sts), .ctl(ctl)
   );

   ogl_datapath u_dp (
      .clock(clock), .reset(reset), .req(req), .csr(csr), .ctl(ctl), .sts(sts),
      .pos_x_mm(rsp.pos_x_mm), .pos_y_mm(rsp.pos_y_mm), .cell_x(rsp.cell_x),
      .cell_y(rsp.cell_y), .trust_x(rsp.trust_x), .trust_y(rsp.trust_y)
   );
endmodule
`default_nettype wire

>>> tb/sv/tb_odometry_grid_localizer.sv
// Self-checking testbench for odometry_grid_localizer: drives items, predicts each result.
// Depends on ogl_pkg, the channel interfaces in ogl_if and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_odometry_grid_localizer;
   localparam longint PosLimit = 64'sd131072 <<< ogl_pkg::PosFracBits;
   localparam int StallLimit = 5000;
   localparam int DrainCycles = 120;

   typedef struct {
      logic [1:0]         op;
      logic signed [15:0] right_speed;
      logic signed [15:0] left_speed;
      logic [8:0]         heading;
      logic [3:0]         sensor_index;
      logic signed [12:0] sensor_dx;
      logic signed [12:0] sensor_dy;
   } move_item;

   typedef struct {
      logic signed [17:0] pos_x_mm;
      logic signed [17:0] pos_y_mm;
      logic signed [9:0]  cell_x;
      logic signed [9:0]  cell_y;
      logic               trust_x;
      logic               trust_y;
   } pose_item;

   // Predicts the pose after each item and checks the block's reports in order.
   class pose_tracker;
      pose_item pending[$];
      int errors;
      longint unsigned gain;
      longint cell_size, limit, wall, margin;
      longint px, py;
      longint store_x[ogl_pkg::SensorCount];
      longint store_y[ogl_pkg::SensorCount];
      bit tx, ty;
      int sine_tab[0:90] = '{0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
         2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
         5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
         8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
         10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
         12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
         14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
         15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
         16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
         16384};

      function new();
         errors = 0;
         gain = 65536; cell_size = 300; limit = 310; wall = 130; margin = 40;
         px = 0; py = 0; tx = 0; ty = 0;
         foreach (store_x[i]) begin
            store_x[i] = 0;
            store_y[i] = 0;
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] data);
         case (idx)
            ogl_pkg::RegGain:   gain = data;
            ogl_pkg::RegCell:   cell_size = data[11:0];
            ogl_pkg::RegLimit:  limit = data[11:0];
            ogl_pkg::RegWall:   wall = data[11:0];
            ogl_pkg::RegMargin: margin = data[11:0];
            default: ;
         endcase
      endfunction

      function longint sine(int d);
         d = d % 360;
         if (d <= 90) return sine_tab[d];
         if (d <= 180) return sine_tab[180 - d];
         if (d <= 270) return -sine_tab[d - 180];
         return -sine_tab[360 - d];
      endfunction

      function longint clamp_pos(longint p);
         if (p < -PosLimit) return -PosLimit;
         if (p > PosLimit - 1) return PosLimit - 1;
         return p;
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      // Half-away rounding of a quotient; den is positive.
      function longint round_div(longint num, longint den);
         longint q;
         q = (2 * mag(num) + den) / (2 * den);
         return num < 0 ? -q : q;
      endfunction

      // Product is in units of 2^-31 mm; round it to the position format.
      function longint step_delta(longint sum, longint s);
         longint prod, q;
         int sh;
         sh = 31 - ogl_pkg::PosFracBits;
         prod = sum * s * longint'(gain);
         q = (mag(prod) + (64'sd1 <<< (sh - 1))) >>> sh;
         return prod < 0 ? -q : q;
      endfunction

      function longint cell_mm();
         return cell_size == 0 ? 1 : cell_size;
      endfunction

      function longint snap_axis(longint p, longint reading);
         longint k;
         k = round_div(p, cell_mm() <<< ogl_pkg::PosFracBits);
         return clamp_pos((k * cell_mm() + mag(reading) - wall) <<< ogl_pkg::PosFracBits);
      endfunction

      function longint cell_index(longint p);
         longint k;
         k = round_div(p, cell_mm() <<< ogl_pkg::PosFracBits);
         if (k < -512) return -512;
         if (k > 511) return 511;
         return k;
      endfunction

      // Nearest mounted sensor, corridor width on each axis, then snap of each trusted axis.
      function void observe(int h);
         longint best, a, d, e, wx, wy;
         int m, ix1, ix3, iy2;
         best = 360;
         m = 0;
         for (int i = 0; i < ogl_pkg::SensorCount; i++) begin
            a = 360 - (i * 360) / ogl_pkg::SensorCount;
            d = mag(a - h);
            e = d < 360 - d ? d : 360 - d;
            if (e < best) begin
               best = e;
               m = i;
            end
         end
         ix1 = (m + ogl_pkg::SensorCount / 4) % ogl_pkg::SensorCount;
         ix3 = (m + (3 * ogl_pkg::SensorCount) / 4) % ogl_pkg::SensorCount;
         iy2 = (m + ogl_pkg::SensorCount / 2) % ogl_pkg::SensorCount;
         wx = mag(store_x[ix1]) + mag(store_x[ix3]) + margin;
         wy = mag(store_y[m]) + mag(store_y[iy2]) + margin;
         tx = wx < limit;
         ty = wy < limit;
         if (tx) px = snap_axis(px, store_x[ix3]);
         if (ty) py = snap_axis(py, store_y[iy2]);
      endfunction

      function void note_item(move_item it);
         pose_item p;
         longint sum;
         int h;
         h = int'(it.heading) % 360;
         case (it.op)
            ogl_pkg::OpOdometry: begin
               sum = longint'(it.right_speed) + longint'(it.left_speed);
               px = clamp_pos(px + step_delta(sum, sine(h)));
               py = clamp_pos(py + step_delta(sum, sine(h + 90)));
            end
            ogl_pkg::OpLoad: begin
               if (it.sensor_index < ogl_pkg::SensorCount) begin
                  store_x[it.sensor_index] = it.sensor_dx;
                  store_y[it.sensor_index] = it.sensor_dy;
               end
            end
            ogl_pkg::OpObserve: observe(h);
            default: ;
         endcase
         p.pos_x_mm = 18'(px >>> ogl_pkg::PosFracBits);
         p.pos_y_mm = 18'(py >>> ogl_pkg::PosFracBits);
         p.cell_x = 10'(cell_index(px));
         p.cell_y = 10'(cell_index(py));
         p.trust_x = tx;
         p.trust_y = ty;
         pending.push_back(p);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch @%0t: %s", $realtime, msg);
      endtask

      task check_pose(pose_item got);
         pose_item want;
         if (pending.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.pos_x_mm !== want.pos_x_mm)
            report($sformatf("pos_x_mm %0d, want %0d", got.pos_x_mm, want.pos_x_mm));
         if (got.pos_y_mm !== want.pos_y_mm)
            report($sformatf("pos_y_mm %0d, want %0d", got.pos_y_mm, want.pos_y_mm));
         if (got.cell_x !== want.cell_x)
            report($sformatf("cell_x %0d, want %0d", got.cell_x, want.cell_x));
         if (got.cell_y !== want.cell_y)
            report($sformatf("cell_y %0d, want %0d", got.cell_y, want.cell_y));
         if (got.trust_x !== want.trust_x)
            report($sformatf("trust_x %0b, want %0b", got.trust_x, want.trust_x));
         if (got.trust_y !== want.trust_y)
            report($sformatf("trust_y %0b, want %0b", got.trust_y, want.trust_y));
      endtask
   endclass

   logic clock;
   logic reset;
   int req_idle;
   int rsp_idle;
   int quiet_cycles;
   pose_tracker tracker;

   ogl_req_if req ();
   ogl_rsp_if rsp ();
   ogl_csr_if csr ();

   odometry_grid_localizer i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #10 clock = ~clock;

   // Response side: check what is taken, then pick the next ready level.
   always @(posedge clock) begin
      pose_item got;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.pos_x_mm = rsp.pos_x_mm;
            got.pos_y_mm = rsp.pos_y_mm;
            got.cell_x = rsp.cell_x;
            got.cell_y = rsp.cell_y;
            got.trust_x = rsp.trust_x;
            got.trust_y = rsp.trust_y;
            tracker.check_pose(got);
         end
         rsp.ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   // Watchdog: any handshake restarts the count.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_move(move_item it);
      if ($urandom_range(99) < req_idle) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle);
      end
      req.valid <= 1'b1;
      req.op <= it.op;
      req.right_speed <= it.right_speed;
      req.left_speed <= it.left_speed;
      req.heading <= it.heading;
      req.sensor_index <= it.sensor_index;
      req.sensor_dx <= it.sensor_dx;
      req.sensor_dy <= it.sensor_dy;
      do @(posedge clock); while (!req.ready);
      tracker.note_item(it);
   endtask

   // Registers change only with the block idle and every result back.
   task automatic set_reg(logic [2:0] idx, logic [23:0] data);
      req.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      tracker.write_reg(idx, data);
   endtask

   function automatic move_item make_move(logic [1:0] op, int rs, int ls, int h,
         int idx, int dx, int dy);
      move_item it;
      it.op = op;
      it.right_speed = 16'(rs);
      it.left_speed = 16'(ls);
      it.heading = 9'(h);
      it.sensor_index = 4'(idx);
      it.sensor_dx = 13'(dx);
      it.sensor_dy = 13'(dy);
      return it;
   endfunction

   // Mostly small readings so observes trust an axis; some full-range noise.
   function automatic int reading();
      if ($urandom_range(9) < 7) return $urandom_range(300) - 150;
      return $urandom_range(8191) - 4096;
   endfunction

   function automatic int speed();
      if ($urandom_range(9) == 0) return $urandom_range(65535) - 32768;
      return $urandom_range(4000) - 2000;
   endfunction

   function automatic move_item random_move();
      move_item it;
      int pick;
      it = make_move(ogl_pkg::OpOdometry, speed(), speed(), $urandom_range(511),
         $urandom_range(15), reading(), reading());
      pick = $urandom_range(99);
      if (pick < 35) it.op = ogl_pkg::OpOdometry;
      else if (pick < 65) it.op = ogl_pkg::OpLoad;
      else if (pick < 95) it.op = ogl_pkg::OpObserve;
      else it.op = ogl_pkg::OpUnused;
      if (it.op == ogl_pkg::OpLoad && $urandom_range(9) != 0)
         it.sensor_index = 4'($urandom_range(11));
      return it;
   endfunction

   task automatic run_phase(int r_idle, int s_idle, int count);
      req_idle = r_idle;
      rsp_idle = s_idle;
      for (int n = 0; n < count; n++) begin
         // A full sensor sweep followed by an observe reaches the snapping path.
         if ($urandom_range(19) == 0) begin
            for (int k = 0; k < ogl_pkg::SensorCount; k++)
               send_move(make_move(ogl_pkg::OpLoad, speed(), speed(), $urandom_range(511),
                  k, $urandom_range(120) - 60, $urandom_range(120) - 60));
            send_move(make_move(ogl_pkg::OpObserve, speed(), speed(), $urandom_range(511),
               0, 0, 0));
         end else begin
            send_move(random_move());
         end
      end
   endtask

   initial begin
      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      req_idle = 0;
      rsp_idle = 0;
      req.valid = 1'b0;
      req.op = ogl_pkg::OpOdometry;
      req.right_speed = '0;
      req.left_speed = '0;
      req.heading = '0;
      req.sensor_index = '0;
      req.sensor_dx = '0;
      req.sensor_dy = '0;
      csr.valid = 1'b0;
      csr.index = ogl_pkg::RegGain;
      csr.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: speed extremes, wrapped headings, bad slots, unused op.
      send_move(make_move(ogl_pkg::OpUnused, 0, 0, 0, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpOdometry, 32767, 32767, 0, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpOdometry, -32768, -32768, 90, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpOdometry, 1000, -500, 450, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpOdometry, 1234, 77, 511, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpOdometry, -3, 2, 359, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpLoad, 0, 0, 0, 0, -4096, 4095));
      send_move(make_move(ogl_pkg::OpLoad, 0, 0, 0, 12, 50, 50));
      send_move(make_move(ogl_pkg::OpLoad, 0, 0, 0, 15, -1, -1));
      send_move(make_move(ogl_pkg::OpObserve, 0, 0, 0, 0, 0, 0));
      for (int k = 0; k < ogl_pkg::SensorCount; k++)
         send_move(make_move(ogl_pkg::OpLoad, 0, 0, 0, k, 60 + k, -(70 + k)));
      send_move(make_move(ogl_pkg::OpObserve, 0, 0, 400, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpObserve, 0, 0, 15, 0, 0, 0));
      send_move(make_move(ogl_pkg::OpUnused, -1, -1, 359, 15, -1, -1));

      // No gain: odometry moves nothing.
      set_reg(ogl_pkg::RegGain, 24'd0);
      send_move(make_move(ogl_pkg::OpOdometry, 32767, 32767, 45, 0, 0, 0));

      // Extreme settings, sender idles less than the receiver.
      set_reg(ogl_pkg::RegGain, 24'hFFFFFF);
      set_reg(ogl_pkg::RegCell, 24'd0);
      set_reg(ogl_pkg::RegLimit, 24'd4095);
      set_reg(ogl_pkg::RegWall, 24'd0);
      set_reg(ogl_pkg::RegMargin, 24'd0);
      run_phase(33, 50, 300);

      // Opposite extremes, receiver idles less.
      set_reg(ogl_pkg::RegGain, 24'($urandom_range(200000)));
      set_reg(ogl_pkg::RegCell, 24'd4095);
      set_reg(ogl_pkg::RegLimit, 24'd0);
      set_reg(ogl_pkg::RegWall, 24'd4095);
      set_reg(ogl_pkg::RegMargin, 24'd4095);
      run_phase(50, 33, 300);

      // Random settings, limit 200 to 600 and margin up to 100, no idling on either side.
      set_reg(ogl_pkg::RegGain, 24'($urandom_range(24'hFFFFFF)));
      set_reg(ogl_pkg::RegCell, 24'($urandom_range(4095, 1)));
      set_reg(ogl_pkg::RegLimit, 24'($urandom_range(600, 200)));
      set_reg(ogl_pkg::RegWall, 24'($urandom_range(4095)));
      set_reg(ogl_pkg::RegMargin, 24'($urandom_range(100)));
      run_phase(0, 0, 320);

      req.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> odometry_grid_localizer.f
+incdir+hw/rtl
hw/rtl/ogl_pkg.sv
hw/rtl/ogl_if.sv
hw/rtl/ogl_datapath.sv
hw/rtl/ogl_controller.sv
hw/rtl/odometry_grid_localizer.sv
tb/sv/tb_odometry_grid_localizer.sv
